@@ hdl/assert_macros.svh @@
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is active.
`define LZVD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define LZVD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/lzvd_pkg.sv @@
// Types and constants of the variable-code LZ decompressor.
package lzvd_pkg;

    localparam int MODE_W   = 2;
    localparam int STATUS_W = 3;
    localparam int VALUE_W  = 24;

    typedef enum logic [MODE_W-1:0] {
        MODE_DICT  = 2'd0,
        MODE_START = 2'd1,
        MODE_FEED  = 2'd2,
        MODE_PULL  = 2'd3
    } mode_t;

    localparam logic [STATUS_W-1:0] ST_BYTE     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NEED     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_COMPLETE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ACCEPTED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BAD_CODE = 3'd5;

    typedef enum logic [2:0] {
        PH_P1  = 3'd0,
        PH_S1  = 3'd1,
        PH_P2  = 3'd2,
        PH_S2  = 3'd3,
        PH_ERR = 3'd4
    } phase_t;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_BITS = 4'b0010,
        S_READ = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

endpackage

@@ hdl/lz_variable_code_decompressor.sv @@
// Top level of the variable-code LZ decompressor.
//
// Items arrive on the s_ stream: s_tuser is the mode (dictionary write, start
// block, feed compressed byte, pull output byte), s_tdata carries the
// dictionary index and the data byte, s_tlast marks the final compressed
// byte. Every item yields exactly one result on the m_ stream: m_tdata is the
// output byte and m_tuser the status code. output_length is written on the
// cfg_ channel, which is always ready.
// One item is worked on at a time. Dictionary writes, block starts and feeds
// go from S_IDLE to S_DONE, then into the output register. A pull walks the
// bit buffer in S_BITS one bit per cycle (up to 8 bits), then reads the
// dictionary or history memory in S_READ when a byte comes out; a pull that
// continues a copy goes straight to S_READ.
// The output register lets a new item enter while a result waits; a stalled
// receiver holds the next result in the block until the register frees.
// Reset clears the parser, counters and output valid flag; the dictionary and
// history memories are not cleared, and the history needs no clearing pass.
module lz_variable_code_decompressor #(
    parameter int WINDOW_DEPTH  = 32768,
    parameter int MAX_CODE_BITS = 24,
    parameter int MIN_MATCH     = 3
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,   // dict_index, data_byte
    input  logic [lzvd_pkg::MODE_W-1:0]   s_tuser,   // mode
    input  logic                          s_tlast,   // last_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // out_byte
    output logic [lzvd_pkg::STATUS_W-1:0] m_tuser,   // status
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [31:0]                   cfg_data
);
    import lzvd_pkg::*;

    localparam int PW = $clog2(WINDOW_DEPTH);
    localparam int DW = $clog2(WINDOW_DEPTH + 1);
    localparam int CW = $clog2(MAX_CODE_BITS + 1);

    state_t                state_reg, state_next;
    phase_t                phase_reg, phase_next;
    logic [31:0]           out_len_reg;
    logic [7:0]            buf_reg, buf_next;
    logic [3:0]            left_reg, left_next;
    logic                  final_reg, final_next;
    logic [VALUE_W-1:0]    pv_reg, pv_next;
    logic [VALUE_W-1:0]    sv_reg, sv_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [DW-1:0]         dist_reg, dist_next;
    logic [25:0]           copy_reg, copy_next;
    logic [31:0]           prod_reg, prod_next;
    logic [PW-1:0]         wp_reg, wp_next;
    logic                  src_dict_reg, src_dict_next;
    logic [7:0]            res_byte_reg, res_byte_next;
    logic [STATUS_W-1:0]   res_st_reg, res_st_next;
    logic                  ov_reg;
    logic [7:0]            ob_reg;
    logic [STATUS_W-1:0]   os_reg;

    logic [7:0]            dictionary [256];
    logic [7:0]            history [WINDOW_DEPTH];
    logic [7:0]            dict_rdata, hist_rdata, rd_byte;
    logic                  dict_re, hist_re, hist_we;
    logic [7:0]            dict_raddr;
    logic [PW-1:0]         hist_raddr;
    logic [PW:0]           diff;

    logic                  s_fire, bit_in, out_load;
    logic [VALUE_W-1:0]    sv_shift;
    logic [24:0]           code;
    logic [24:0]           dist_full;
    logic [CW:0]           cnt_inc;

    assign s_tready  = (state_reg == S_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = ov_reg;
    assign m_tdata   = ob_reg;
    assign m_tuser   = os_reg;
    assign out_load  = (state_reg == S_DONE) && (!ov_reg || m_tready);

    // Copy source: back by the match distance, modulo the window.
    always_comb
    begin
        diff = {1'b0, wp_reg} - (PW + 1)'(dist_reg);
        if (dist_reg == DW'(WINDOW_DEPTH))
        begin
            hist_raddr = wp_reg;
        end
        else if ({1'b0, wp_reg} >= (PW + 1)'(dist_reg))
        begin
            hist_raddr = diff[PW-1:0];
        end
        else
        begin
            hist_raddr = PW'(diff + (PW + 1)'(WINDOW_DEPTH));
        end
    end

    assign bit_in    = buf_reg[7];
    assign sv_shift  = {sv_reg[VALUE_W-2:0], bit_in};
    assign code      = {1'b0, pv_reg} + {1'b0, sv_shift};
    assign dist_full = code - 25'd256;
    assign cnt_inc   = {1'b0, cnt_reg} + (CW + 1)'(1);
    assign rd_byte   = src_dict_reg ? dict_rdata : hist_rdata;

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        buf_next      = buf_reg;
        left_next     = left_reg;
        final_next    = final_reg;
        pv_next       = pv_reg;
        sv_next       = sv_reg;
        cnt_next      = cnt_reg;
        dist_next     = dist_reg;
        copy_next     = copy_reg;
        prod_next     = prod_reg;
        wp_next       = wp_reg;
        src_dict_next = src_dict_reg;
        res_byte_next = res_byte_reg;
        res_st_next   = res_st_reg;
        dict_re       = 1'b0;
        dict_raddr    = code[7:0];
        hist_re       = 1'b0;
        hist_we       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_fire)
                begin
                    res_byte_next = 8'd0;
                    res_st_next   = ST_ACCEPTED;
                    state_next    = S_DONE;
                    case (mode_t'(s_tuser))
                        MODE_DICT:
                        begin
                        end
                        MODE_START:
                        begin
                            buf_next   = 8'd0;
                            left_next  = 4'd0;
                            final_next = 1'b0;
                            phase_next = PH_P1;
                            pv_next    = '0;
                            sv_next    = '0;
                            cnt_next   = '0;
                            dist_next  = '0;
                            copy_next  = '0;
                            prod_next  = '0;
                            wp_next    = '0;
                        end
                        MODE_FEED:
                        begin
                            if (left_reg != 4'd0 || final_reg)
                            begin
                                res_st_next = ST_REJECTED;
                            end
                            else
                            begin
                                buf_next   = s_tdata[15:8];
                                left_next  = 4'd8;
                                final_next = s_tlast;
                            end
                        end
                        MODE_PULL:
                        begin
                            if (phase_reg == PH_ERR)
                            begin
                                res_st_next = ST_BAD_CODE;
                            end
                            else if (prod_reg >= out_len_reg)
                            begin
                                copy_next   = '0;
                                res_st_next = ST_COMPLETE;
                            end
                            else if (copy_reg != '0)
                            begin
                                hist_re       = 1'b1;
                                src_dict_next = 1'b0;
                                state_next    = S_READ;
                            end
                            else
                            begin
                                state_next = S_BITS;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // One buffered bit is consumed per cycle.
            S_BITS:
            begin
                if (left_reg == 4'd0)
                begin
                    res_st_next = final_reg ? ST_COMPLETE : ST_NEED;
                    state_next  = S_DONE;
                end
                else
                begin
                    left_next = left_reg - 4'd1;
                    buf_next  = {buf_reg[6:0], 1'b0};
                    if (phase_reg == PH_P1 || phase_reg == PH_P2)
                    begin
                        if (bit_in && cnt_inc >= (CW + 1)'(MAX_CODE_BITS))
                        begin
                            phase_next  = PH_ERR;
                            res_st_next = ST_BAD_CODE;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            pv_next  = {pv_reg[VALUE_W-2:0], bit_in};
                            cnt_next = cnt_inc[CW-1:0];
                            if (!bit_in)
                            begin
                                sv_next    = '0;
                                phase_next = (phase_reg == PH_P1) ? PH_S1 : PH_S2;
                            end
                        end
                    end
                    else
                    begin
                        sv_next  = sv_shift;
                        cnt_next = cnt_reg - CW'(1);
                        if (cnt_reg == CW'(1))
                        begin
                            pv_next = '0;
                            sv_next = '0;
                            if (phase_reg == PH_S1)
                            begin
                                if (code < 25'd256)
                                begin
                                    phase_next    = PH_P1;
                                    dict_re       = 1'b1;
                                    src_dict_next = 1'b1;
                                    state_next    = S_READ;
                                end
                                else if (dist_full == '0 || {7'd0, dist_full} > prod_reg
                                         || dist_full > 25'(WINDOW_DEPTH))
                                begin
                                    phase_next  = PH_ERR;
                                    res_st_next = ST_BAD_CODE;
                                    state_next  = S_DONE;
                                end
                                else
                                begin
                                    dist_next  = dist_full[DW-1:0];
                                    phase_next = PH_P2;
                                end
                            end
                            else
                            begin
                                copy_next     = {1'b0, code} + 26'(MIN_MATCH);
                                phase_next    = PH_P1;
                                hist_re       = 1'b1;
                                src_dict_next = 1'b0;
                                state_next    = S_READ;
                            end
                        end
                    end
                end
            end

            // Read data is back: emit it and append it to the history.
            S_READ:
            begin
                if (!src_dict_reg)
                begin
                    copy_next = copy_reg - 26'd1;
                end
                hist_we       = 1'b1;
                wp_next       = (wp_reg == PW'(WINDOW_DEPTH - 1)) ? '0 : wp_reg + PW'(1);
                prod_next     = prod_reg + 32'd1;
                res_byte_next = rd_byte;
                res_st_next   = ST_BYTE;
                state_next    = S_DONE;
            end

            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            phase_reg    <= PH_P1;
            out_len_reg  <= '0;
            buf_reg      <= '0;
            left_reg     <= '0;
            final_reg    <= 1'b0;
            pv_reg       <= '0;
            sv_reg       <= '0;
            cnt_reg      <= '0;
            dist_reg     <= '0;
            copy_reg     <= '0;
            prod_reg     <= '0;
            wp_reg       <= '0;
            src_dict_reg <= 1'b0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            buf_reg      <= buf_next;
            left_reg     <= left_next;
            final_reg    <= final_next;
            pv_reg       <= pv_next;
            sv_reg       <= sv_next;
            cnt_reg      <= cnt_next;
            dist_reg     <= dist_next;
            copy_reg     <= copy_next;
            prod_reg     <= prod_next;
            wp_reg       <= wp_next;
            src_dict_reg <= src_dict_next;
            if (cfg_valid && cfg_ready)
            begin
                out_len_reg <= cfg_data;
            end
            if (out_load)
            begin
                ov_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_byte_reg <= res_byte_next;
        res_st_reg   <= res_st_next;
        if (out_load)
        begin
            ob_reg <= res_byte_reg;
            os_reg <= res_st_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire && mode_t'(s_tuser) == MODE_DICT)
        begin
            dictionary[s_tdata[7:0]] <= s_tdata[15:8];
        end
        if (dict_re)
        begin
            dict_rdata <= dictionary[dict_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            history[wp_reg] <= rd_byte;
        end
        if (hist_re)
        begin
            hist_rdata <= history[hist_raddr];
        end
    end

endmodule

@@ hdl/lzvd_checker.sv @@
// Port-level assertion checker for the decompressor, with its bind.
`include "assert_macros.svh"

module lzvd_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [7:0]                    m_tdata,
    input logic [lzvd_pkg::STATUS_W-1:0] m_tuser
);
    import lzvd_pkg::*;

    `LZVD_ASSERT(a_out_hold, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
    `LZVD_ASSERT(a_status_range, clk, rst_n, m_tvalid |-> m_tuser <= ST_BAD_CODE, "status code out of range")
    `LZVD_ASSERT(a_byte_zero, clk, rst_n, m_tvalid && m_tuser != ST_BYTE |-> m_tdata == 8'd0, "data set without a byte status")
    `LZVD_ASSERT(a_one_item, clk, rst_n, s_tvalid && s_tready |=> !s_tready, "second transaction taken while busy")

endmodule

bind lz_variable_code_decompressor lzvd_checker u_lzvd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

@@ test/tb_top.sv @@
// Self-checking testbench of the variable-code LZ decompressor.
module tb_top;
    import lzvd_pkg::*;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] index;
        logic [7:0] data;
        logic       last;
    } lz_item_t;

    typedef struct packed {
        logic [7:0] obyte;
        logic [2:0] status;
    } lz_result_t;

    localparam int WIN = 32768;
    localparam int MAXB = 24;
    localparam int MINM = 3;
    localparam int CYCLE_LIMIT = 2000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [15:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [2:0] m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [31:0] cfg_data = '0;

    lz_variable_code_decompressor DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    // Predictor state.
    logic [7:0]  dict_mem [256];
    logic [7:0]  hist_mem [WIN];
    logic [31:0] out_len;
    logic [7:0]  bbuf;
    int unsigned nbits, fin, phase, pval, sval, pcnt, back_dist, crem, produced, wptr;

    lz_item_t   pending_items [$];
    lz_result_t expected_results [$];
    int errors = 0;
    int pulls_with_byte = 0;
    int bad_codes = 0;
    int feeds_sent = 0;
    bit quiet_phase = 0;
    bit hold_rx = 0;
    int tx_gap = 0, rx_gap = 0;

    function automatic void clear_block();
        bbuf = 0; nbits = 0; fin = 0; phase = PH_P1; pval = 0; sval = 0;
        pcnt = 0; back_dist = 0; crem = 0; produced = 0; wptr = 0;
    endfunction

    function automatic logic [7:0] emit_byte(logic [7:0] b);
        hist_mem[wptr] = b;
        wptr = (wptr + 1) % WIN;
        produced++;
        return b;
    endfunction

    function automatic logic [7:0] copy_out();
        int unsigned src;
        src = (wptr + WIN - (back_dist % WIN)) % WIN;
        crem--;
        return emit_byte(hist_mem[src]);
    endfunction

    function automatic lz_result_t decode_pull();
        lz_result_t r;
        int unsigned bitv, code;
        r = '{obyte: 8'd0, status: ST_BYTE};
        if (phase == PH_ERR)
        begin
            r.status = ST_BAD_CODE;
            return r;
        end
        if (produced >= out_len)
        begin
            crem = 0;
            r.status = ST_COMPLETE;
            return r;
        end
        if (crem != 0)
        begin
            r.obyte = copy_out();
            return r;
        end
        forever
        begin
            if (nbits == 0)
            begin
                r.status = fin ? ST_COMPLETE : ST_NEED;
                return r;
            end
            nbits--;
            bitv = (bbuf >> (nbits & 7)) & 8'h01;
            if (phase == PH_P1 || phase == PH_P2)
            begin
                if (bitv == 1 && pcnt + 1 >= MAXB)
                begin
                    phase = PH_ERR;
                    r.status = ST_BAD_CODE;
                    return r;
                end
                pval = ((pval << 1) | bitv) & 24'hFFFFFF;
                pcnt++;
                if (bitv == 0)
                begin
                    sval = 0;
                    phase = (phase == PH_P1) ? PH_S1 : PH_S2;
                end
            end
            else
            begin
                sval = ((sval << 1) | bitv) & 24'hFFFFFF;
                pcnt--;
                if (pcnt == 0)
                begin
                    code = pval + sval;
                    pval = 0; sval = 0;
                    if (phase == PH_S1)
                    begin
                        if (code < 256)
                        begin
                            phase = PH_P1;
                            r.obyte = emit_byte(dict_mem[code]);
                            return r;
                        end
                        back_dist = code - 256;
                        if (back_dist == 0 || back_dist > produced || back_dist > WIN)
                        begin
                            phase = PH_ERR;
                            r.status = ST_BAD_CODE;
                            return r;
                        end
                        phase = PH_P2;
                    end
                    else
                    begin
                        crem = code + MINM;
                        phase = PH_P1;
                        r.obyte = copy_out();
                        return r;
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic lz_result_t predict_item(lz_item_t it);
        lz_result_t r;
        r = '{obyte: 8'd0, status: ST_ACCEPTED};
        case (it.mode)
            MODE_DICT: dict_mem[it.index] = it.data;
            MODE_START: clear_block();
            MODE_FEED:
                if (nbits != 0 || fin) r.status = ST_REJECTED;
                else
                begin
                    bbuf = it.data;
                    nbits = 8;
                    fin = it.last;
                end
            default: r = decode_pull();
        endcase
        return r;
    endfunction

    // Driver: the predictor runs at acceptance so its state follows the stream.
    always @(posedge clk)
    begin
        lz_result_t pred;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                pred = predict_item(pending_items.pop_front());
                expected_results = {expected_results, pred};
            end
            if (!(s_tvalid && !s_tready))
            begin
                if (tx_gap > 0)
                begin
                    tx_gap <= tx_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (!quiet_phase && $urandom_range(0, 9) == 0)
                begin
                    tx_gap <= $urandom_range(1, 7);
                    s_tvalid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tuser  <= pending_items[0].mode;
                    s_tdata  <= {pending_items[0].data, pending_items[0].index};
                    s_tlast  <= pending_items[0].last;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor and receiver stall control.
    always @(posedge clk)
    begin
        lz_result_t got, want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = '{obyte: m_tdata, status: m_tuser};
                if (expected_results.size() == 0)
                begin
                    $error("result with no expectation: out_byte %0d status %0d",
                           got.obyte, got.status);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.status != want.status)
                    begin
                        $error("status: expected %0d actual %0d", want.status, got.status);
                        errors++;
                    end
                    if (got.obyte != want.obyte)
                    begin
                        $error("out_byte: expected %0d actual %0d", want.obyte, got.obyte);
                        errors++;
                    end
                    if (want.status == ST_BYTE) pulls_with_byte++;
                    if (want.status == ST_BAD_CODE) bad_codes++;
                end
            end
            if (hold_rx) m_tready <= 1'b0;
            else if (rx_gap > 0)
            begin
                rx_gap <= rx_gap - 1;
                m_tready <= 1'b0;
            end
            else if (!quiet_phase && $urandom_range(0, 9) == 0)
            begin
                rx_gap <= $urandom_range(1, 7);
                m_tready <= 1'b0;
            end
            else m_tready <= 1'b1;
        end
    end

    // Cycle limit.
    initial
    begin
        int cycles;
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic push(logic [1:0] m, logic [7:0] i, logic [7:0] d, logic l);
        lz_item_t it;
        it = '{mode: m, index: i, data: d, last: l};
        pending_items = {pending_items, it};
    endtask

    task automatic drain_all();
        while (pending_items.size() != 0 || expected_results.size() != 0 || s_tvalid)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_len(logic [31:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        out_len = v;
    endtask

    // Bit writer for the compressed streams.
    logic bitq [$];

    task automatic put_code(int unsigned v);
        int n, p;
        n = 0;
        while (((1 << (n + 1)) - 2) <= v) n++;
        p = (1 << n) - 2;
        if (n == 0)
        begin
            n = 1;
            p = 0;
        end
        for (int k = 0; k < n - 1; k++) bitq = {bitq, 1'b1};
        bitq = {bitq, 1'b0};
        for (int k = n - 1; k >= 0; k--) bitq = {bitq, 1'(((v - p) >> k) & 1)};
    endtask

    // Prefix of n bits "1..10" equals 2^n-2; suffix of n bits covers values up to 2^(n+1)-3.
    task automatic flush_bits(bit add_pulls);
        logic [7:0] b;
        while (bitq.size() != 0)
        begin
            b = '0;
            for (int k = 7; k >= 0; k--) b[k] = bitq.size() ? bitq.pop_front() : 1'b0;
            push(MODE_FEED, 8'($urandom), b, bitq.size() == 0 && $urandom_range(0, 1));
            feeds_sent++;
            if (add_pulls)
                repeat ($urandom_range(1, 4)) push(MODE_PULL, 8'($urandom), 8'($urandom), 1'b0);
        end
    endtask

    task automatic random_block();
        int made, n, d, len;
        push(MODE_START, 8'($urandom), 8'($urandom), 1'($urandom));
        made = 0;
        n = $urandom_range(2, 12);
        for (int k = 0; k < n; k++)
        begin
            if (made > 0 && $urandom_range(0, 2) == 0)
            begin
                d = $urandom_range(1, made);
                if ($urandom_range(0, 15) == 0) d = made + 1;
                put_code(256 + d);
                len = $urandom_range(0, 5);
                put_code(len);
                made += len + MINM;
            end
            else
            begin
                put_code($urandom_range(0, 255));
                made++;
            end
        end
        if ($urandom_range(0, 9) == 0) repeat (26) bitq = {bitq, 1'b1};
        flush_bits(1);
        repeat ($urandom_range(1, 6)) push(MODE_PULL, 8'($urandom), 8'($urandom), 1'b0);
        if ($urandom_range(0, 4) == 0)
        begin
            push(MODE_FEED, 8'($urandom), 8'($urandom), 1'($urandom));
            push(MODE_PULL, 8'($urandom), 8'($urandom), 1'b0);
        end
    endtask

    initial
    begin
        for (int k = 0; k < 256; k++) dict_mem[k] = 0;
        out_len = 0;
        clear_block();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: fill the dictionary so no pull reads an unwritten entry.
        for (int k = 0; k < 256; k++) push(MODE_DICT, k[7:0], 8'($urandom), 1'($urandom));
        drain_all();
        write_len(32'd0);
        push(MODE_DICT, 8'hFF, 8'hFF, 1'b1);
        push(MODE_DICT, 8'h00, 8'h00, 1'b0);
        push(MODE_PULL, 8'h00, 8'h00, 1'b0);
        drain_all();
        write_len(32'hFFFFFFFF);
        push(MODE_START, 8'h00, 8'h00, 1'b0);
        push(MODE_PULL, 8'hFF, 8'hFF, 1'b1);
        put_code(0); put_code(255); put_code(257); put_code(0);
        flush_bits(0);
        push(MODE_FEED, 8'hAA, 8'h55, 1'b1);
        repeat (10) push(MODE_PULL, 8'h00, 8'h00, 1'b0);
        push(MODE_START, 8'h00, 8'h00, 1'b0);
        bitq.delete();
        put_code(256);
        flush_bits(1);
        push(MODE_FEED, 8'h00, 8'hFF, 1'b1);
        push(MODE_PULL, 8'h00, 8'h00, 1'b0);
        push(MODE_START, 8'h00, 8'h00, 1'b0);
        repeat (4)
        begin
            push(MODE_FEED, 8'h00, 8'hFF, 1'b0);
            repeat (3) push(MODE_PULL, 8'h00, 8'h00, 1'b0);
        end
        drain_all();

        // Long receiver stall while the sender keeps offering.
        for (int k = 0; k < 40; k++) push(MODE_DICT, k[7:0], 8'($urandom), 1'b0);
        hold_rx = 1;
        repeat (300) @(posedge clk);
        hold_rx = 0;
        drain_all();

        for (int phase_i = 0; phase_i < 5; phase_i++)
        begin
            case (phase_i)
                0: write_len(32'd1000);
                1: write_len(32'($urandom_range(1, 20)));
                2: write_len(32'($urandom));
                3: write_len(32'd0);
                default: write_len(32'hFFFFFFFF);
            endcase
            if (phase_i == 4) quiet_phase = 1;
            while (pending_items.size() < 160)
            begin
                if ($urandom_range(0, 9) == 0)
                    push(2'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
                else random_block();
            end
            drain_all();
        end

        $display("Covered directed extremes, a long output stall and five length settings;");
        $display("%0d bytes decoded, %0d bad codes, %0d feeds sent.",
                 pulls_with_byte, bad_codes, feeds_sent);
        if (errors == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+hdl
hdl/lzvd_pkg.sv
hdl/lz_variable_code_decompressor.sv
hdl/lzvd_checker.sv
test/tb_top.sv
